// ----- rtl/ledtail_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ledtail_pkg;

    localparam int MAX_LEDS_DEFAULT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int LED_COUNT_W = 7;
    localparam int TAIL_LEN_W  = 7;
    localparam int FADE_LEN_W  = 4;
    localparam int LED_INDEX_W = 6;
    localparam int COLOR_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_LENGTH = 2'd2;

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET   = 7'd46;
    localparam logic [TAIL_LEN_W-1:0]  TAIL_LENGTH_RESET = 7'd10;
    localparam logic [FADE_LEN_W-1:0]  FADE_LENGTH_RESET = 4'd3;

    typedef enum logic [1:0] {
        HUE_RED   = 2'd0,
        HUE_WHITE = 2'd1,
        HUE_BLUE  = 2'd2
    } t_hue;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic start;    // frame tick accepted: apply restart and hue change
        logic prep;     // derive the per-frame tail bounds
        logic emit;     // compute one LED and load the output register
        logic advance;  // move the head at the end of the frame
    } t_ctrl_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_led;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb hue_rgb(input t_hue hue);
        t_rgb c;
        unique case (hue)
            HUE_WHITE: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            HUE_BLUE:  c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            default:   c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

    function automatic t_hue next_hue(input t_hue hue);
        t_hue h;
        unique case (hue)
            HUE_RED:   h = HUE_WHITE;
            HUE_WHITE: h = HUE_BLUE;
            default:   h = HUE_RED;
        endcase
        return h;
    endfunction

    // Full intensity divided by five times (step + 1).
    function automatic logic [COLOR_W-1:0] fade_level(input logic [FADE_LEN_W-1:0] step);
        logic [COLOR_W-1:0] v;
        unique case (step)
            4'd0:  v = 8'd51;
            4'd1:  v = 8'd25;
            4'd2:  v = 8'd17;
            4'd3:  v = 8'd12;
            4'd4:  v = 8'd10;
            4'd5:  v = 8'd8;
            4'd6:  v = 8'd7;
            4'd7:  v = 8'd6;
            4'd8:  v = 8'd5;
            4'd9:  v = 8'd5;
            4'd10: v = 8'd4;
            4'd11: v = 8'd4;
            default: v = 8'd3;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/led_strip_fading_tail_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Fading-tail LED strip generator. Each accepted beat on the input channel is
// one frame tick (i_restart starts the animation over); the block answers with
// one beat per LED in index order, o_last_led marking the final one. A frame
// is worked in steps: the tick is taken, the frame's tail bounds are derived,
// then the LEDs go out one per cycle, while the output is not stalled, through
// the output register, which holds while i_out_stall is high. No new tick is
// taken until the frame is done. A frame with an LED count of zero produces no
// beats. Configuration writes are always accepted and must be issued while
// no frame is in progress.
module led_strip_fading_tail_generator_core
    import ledtail_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_restart,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [LED_INDEX_W-1:0]      o_led_index,
    output logic [COLOR_W-1:0]          o_red,
    output logic [COLOR_W-1:0]          o_green,
    output logic [COLOR_W-1:0]          o_blue,
    output logic                        o_last_led
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ledtail_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ledtail_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_restart   (i_restart),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_led_index (o_led_index),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_last_led  (o_last_led)
    );

endmodule

`default_nettype wire

// ----- rtl/ledtail_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ledtail_ctrl
    import ledtail_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    // An empty strip produces no beats for the frame.
                    if (!i_status.count_zero) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_led) begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ledtail_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ledtail_datapath
    import ledtail_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_restart,
    input  wire t_ctrl_cmd              i_cmd,
    output t_dp_status                  o_status,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [LED_INDEX_W-1:0]      o_led_index,
    output logic [COLOR_W-1:0]          o_red,
    output logic [COLOR_W-1:0]          o_green,
    output logic [COLOR_W-1:0]          o_blue,
    output logic                        o_last_led
);

    localparam int PW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam int SW = CW + 6;

    // Configuration registers.
    logic [LED_COUNT_W-1:0] r_led_count;
    logic [TAIL_LEN_W-1:0]  r_tail_length;
    logic [FADE_LEN_W-1:0]  r_fade_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count   <= LED_COUNT_RESET;
            r_tail_length <= TAIL_LENGTH_RESET;
            r_fade_length <= FADE_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LED_COUNT:   r_led_count   <= i_cfg_data[LED_COUNT_W-1:0];
                CFG_TAIL_LENGTH: r_tail_length <= i_cfg_data[TAIL_LEN_W-1:0];
                CFG_FADE_LENGTH: r_fade_length <= i_cfg_data[FADE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped strip and tail lengths.
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_tail;

    always_comb begin
        if (int'(r_led_count) > MAX_LEDS) begin
            w_count = CW'(MAX_LEDS);
        end else begin
            w_count = CW'(r_led_count);
        end
        if (r_tail_length == '0) begin
            w_tail = CW'(1);
        end else if (int'(r_tail_length) > MAX_LEDS) begin
            w_tail = CW'(MAX_LEDS);
        end else begin
            w_tail = CW'(r_tail_length);
        end
    end

    logic signed [SW-1:0] w_n;
    logic signed [SW-1:0] w_t;
    logic signed [SW-1:0] w_f;

    assign w_n = signed'(SW'(w_count));
    assign w_t = signed'(SW'(w_tail));
    assign w_f = signed'(SW'(r_fade_length));

    // Frame state kept between ticks.
    logic [PW-1:0] r_head;
    t_hue          r_cur_hue;
    t_hue          r_prior_hue;
    logic [PW-1:0] n_head;
    t_hue          n_cur_hue;
    t_hue          n_prior_hue;
    logic [PW-1:0] w_start_head;
    t_hue          w_start_hue;

    // Per-frame bounds, derived once before the LEDs are walked.
    logic signed [SW-1:0] r_p;
    logic signed [SW-1:0] r_p_f;
    logic signed [SW-1:0] r_p_t;
    logic signed [SW-1:0] r_p_t_f;
    logic signed [SW-1:0] r_wrap;
    logic signed [SW-1:0] r_wrap_f;
    logic signed [SW-1:0] r_n_t;
    logic signed [SW-1:0] r_low_lit;
    logic signed [SW-1:0] r_last_idx;
    logic                 r_p_lt_t;
    logic                 r_p_lt_t1;
    logic                 r_p_lt_n_t;
    logic [PW-1:0]        r_idx;

    always_comb begin
        w_start_head = i_restart ? PW'(w_tail - CW'(1)) : r_head;
        w_start_hue  = i_restart ? HUE_RED : r_cur_hue;
        n_head       = r_head;
        n_cur_hue    = r_cur_hue;
        n_prior_hue  = r_prior_hue;
        if (i_cmd.start) begin
            n_cur_hue = w_start_hue;
            if (w_start_head == '0) begin
                n_prior_hue = w_start_hue;
                n_cur_hue   = next_hue(w_start_hue);
            end
            n_head = (w_count == '0) ? '0 : w_start_head;
        end else if (i_cmd.advance) begin
            if (r_p >= r_last_idx) begin
                n_head = '0;
            end else begin
                n_head = r_head + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_cur_hue   <= HUE_RED;
            r_prior_hue <= HUE_RED;
        end else begin
            r_head      <= n_head;
            r_cur_hue   <= n_cur_hue;
            r_prior_hue <= n_prior_hue;
        end
    end

    logic signed [SW-1:0] w_p;
    assign w_p = signed'(SW'(r_head));

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_p        <= w_p;
            r_p_f      <= w_p - w_f;
            r_p_t      <= w_p - w_t;
            r_p_t_f    <= w_p - w_t + w_f;
            r_wrap     <= w_n - w_t + w_p;
            r_wrap_f   <= w_n - w_t + w_p + w_f;
            r_n_t      <= w_n - w_t;
            r_low_lit  <= w_n + w_p - w_t + SW'(1);
            r_last_idx <= w_n - SW'(1);
            r_p_lt_t   <= w_p < w_t;
            r_p_lt_t1  <= w_p < (w_t - SW'(1));
            r_p_lt_n_t <= w_p < (w_n - w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + PW'(1);
        end
    end

    // One LED of the frame.
    logic signed [SW-1:0]  w_i;
    logic signed [SW-1:0]  w_delta;
    logic signed [SW-1:0]  w_step;
    logic                  w_near_head;
    logic                  w_near_tail;
    logic                  w_near_wrap;
    logic                  w_lit;
    logic                  w_is_last;
    t_rgb                  w_full;
    t_rgb                  w_color;
    logic [COLOR_W-1:0]    w_level;

    assign w_i       = signed'(SW'(r_idx));
    assign w_is_last = (w_i == r_last_idx);

    always_comb begin
        w_near_head = (w_i <= r_p) && (w_i >= r_p_f);
        w_near_tail = (w_i >= r_p_t) && (w_i <= r_p_t_f);
        w_near_wrap = r_p_lt_t && (w_i >= r_wrap) && (w_i <= r_wrap_f);
        priority if (w_near_head) begin
            w_delta = r_p - w_i;
        end else if (w_near_tail) begin
            w_delta = w_i - r_p_t;
        end else begin
            w_delta = w_i - r_wrap;
        end
        w_step  = w_f - w_delta;
        w_level = fade_level(w_step[FADE_LEN_W-1:0]);
        w_full  = hue_rgb(r_cur_hue);
        w_color = w_full;
        if (w_near_head || w_near_tail || w_near_wrap) begin
            // Channels are either full or off, so dimming just picks a level.
            w_color.red   = (w_full.red   != '0) ? w_level : '0;
            w_color.green = (w_full.green != '0) ? w_level : '0;
            w_color.blue  = (w_full.blue  != '0) ? w_level : '0;
        end
        // Just after a wrap the far end of the strip keeps the old colour.
        if (r_p_lt_n_t && (w_i > r_n_t)) begin
            w_color = hue_rgb(r_prior_hue);
        end
        if (r_p_lt_t1) begin
            w_lit = (w_i <= r_p) || (w_i >= r_low_lit);
        end else begin
            w_lit = (w_i <= r_p) && (w_i > r_p_t);
        end
        if (!w_lit) begin
            w_color = '0;
        end
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_led_index <= LED_INDEX_W'(r_idx);
            o_red       <= w_color.red;
            o_green     <= w_color.green;
            o_blue      <= w_color.blue;
            o_last_led  <= w_is_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status.count_zero = (w_count == '0);
    assign o_status.last_led   = w_is_last;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire
